FILE: sv/scl_pkg.sv
// Package for the shell command lexer: token kinds, lexer mode codes,
// character constants, result item types and character classes.
// No dependencies.
`default_nettype none
package scl_pkg;

    localparam logic [3:0] K_STRING = 4'd0;
    localparam logic [3:0] K_VAR    = 4'd1;
    localparam logic [3:0] K_SEPAR  = 4'd2;
    localparam logic [3:0] K_END    = 4'd3;
    localparam logic [3:0] K_SEMI   = 4'd4;
    localparam logic [3:0] K_OROR   = 4'd5;
    localparam logic [3:0] K_ANDAND = 4'd6;
    localparam logic [3:0] K_PIPE   = 4'd7;
    localparam logic [3:0] K_LT     = 4'd8;
    localparam logic [3:0] K_GT     = 4'd9;
    localparam logic [3:0] K_UNIMPL = 4'd10;
    localparam logic [3:0] K_QERR   = 4'd11;

    localparam logic [3:0] M_START  = 4'd0;
    localparam logic [3:0] M_IDLE   = 4'd1;
    localparam logic [3:0] M_SEPAR  = 4'd2;
    localparam logic [3:0] M_WORD   = 4'd3;
    localparam logic [3:0] M_QUOTE  = 4'd4;
    localparam logic [3:0] M_PIPE   = 4'd5;
    localparam logic [3:0] M_AMP    = 4'd6;
    localparam logic [3:0] M_DOLLAR = 4'd7;
    localparam logic [3:0] M_VAR    = 4'd8;

    localparam logic [7:0] C_NUL    = 8'h00;
    localparam logic [7:0] C_TAB    = 8'h09;
    localparam logic [7:0] C_LF     = 8'h0A;
    localparam logic [7:0] C_VT     = 8'h0B;
    localparam logic [7:0] C_FF     = 8'h0C;
    localparam logic [7:0] C_CR     = 8'h0D;
    localparam logic [7:0] C_SPACE  = 8'h20;
    localparam logic [7:0] C_DQUOTE = 8'h22;
    localparam logic [7:0] C_DOLLAR = 8'h24;
    localparam logic [7:0] C_AMP    = 8'h26;
    localparam logic [7:0] C_SQUOTE = 8'h27;
    localparam logic [7:0] C_SEMI   = 8'h3B;
    localparam logic [7:0] C_LT     = 8'h3C;
    localparam logic [7:0] C_GT     = 8'h3E;
    localparam logic [7:0] C_PIPE   = 8'h7C;

    localparam int unsigned MAX_RES = 3;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       is_text;
        logic [3:0] tok_kind;
    } t_res;

    typedef struct packed {
        t_res [MAX_RES-1:0] items;
        logic [1:0]         cnt;
    } t_bundle;

    typedef struct packed {
        t_bundle    res;
        logic [3:0] mode;
        logic       quote_dbl;
    } t_step;

    function automatic logic is_ws(input logic [7:0] c);
        return c == C_SPACE || c == C_TAB || c == C_LF || c == C_VT ||
               c == C_FF || c == C_CR;
    endfunction

    function automatic logic is_alnum(input logic [7:0] c);
        return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A) ||
               (c >= 8'h61 && c <= 8'h7A);
    endfunction

    function automatic logic is_quote(input logic [7:0] c);
        return c == C_DQUOTE || c == C_SQUOTE;
    endfunction

    function automatic logic ends_word(input logic [7:0] c);
        return c == C_NUL || is_ws(c) || c == C_PIPE || c == C_LT || c == C_GT ||
               c == C_SEMI || c == C_AMP || c == C_DOLLAR || is_quote(c);
    endfunction

    function automatic t_res mk_res(input logic [3:0] kind, input logic txt,
                                    input logic [7:0] b);
        t_res r;
        r.tok_kind  = kind;
        r.is_text   = txt;
        r.text_byte = txt ? b : 8'h00;
        return r;
    endfunction

endpackage
`default_nettype wire

FILE: sv/scl_classify.sv
// Classifier: from the lexer mode and one character, the results of that
// character and the next mode. Depends on scl_pkg.
`default_nettype none
module scl_classify import scl_pkg::*; (
    input  wire logic [7:0] i_char,
    input  wire logic [3:0] i_mode,
    input  wire logic       i_quote_dbl,
    output t_step           o_step
);

    logic       bt_has;
    t_res       bt_item;
    logic [3:0] bt_mode;
    logic       bt_qd_wr;
    logic       bt_qd;
    logic [1:0] k;
    logic       use_bt;
    logic [7:0] close_q;

    always_comb begin
        bt_has   = 1'b0;
        bt_item  = mk_res(K_STRING, 1'b0, 8'h00);
        bt_mode  = M_IDLE;
        bt_qd_wr = 1'b0;
        bt_qd    = 1'b0;
        if (is_ws(i_char)) begin
            bt_mode = M_SEPAR;
        end else if (i_char == C_NUL) begin
            bt_has   = 1'b1;
            bt_item  = mk_res(K_END, 1'b0, 8'h00);
            bt_mode  = M_START;
            bt_qd_wr = 1'b1;
        end else if (i_char == C_SEMI) begin
            bt_has  = 1'b1;
            bt_item = mk_res(K_SEMI, 1'b0, 8'h00);
        end else if (i_char == C_PIPE) begin
            bt_mode = M_PIPE;
        end else if (i_char == C_AMP) begin
            bt_mode = M_AMP;
        end else if (i_char == C_LT) begin
            bt_has  = 1'b1;
            bt_item = mk_res(K_LT, 1'b0, 8'h00);
        end else if (i_char == C_GT) begin
            bt_has  = 1'b1;
            bt_item = mk_res(K_GT, 1'b0, 8'h00);
        end else if (i_char == C_DOLLAR) begin
            bt_mode = M_DOLLAR;
        end else if (is_quote(i_char)) begin
            bt_mode  = M_QUOTE;
            bt_qd_wr = 1'b1;
            bt_qd    = (i_char == C_DQUOTE);
        end else begin
            bt_has  = 1'b1;
            bt_item = mk_res(K_STRING, 1'b1, i_char);
            bt_mode = M_WORD;
        end
    end

    assign close_q = i_quote_dbl ? C_DQUOTE : C_SQUOTE;

    always_comb begin
        o_step           = '0;
        o_step.mode      = i_mode;
        o_step.quote_dbl = i_quote_dbl;
        k                = 2'd0;
        use_bt           = 1'b0;
        case (i_mode)
            M_IDLE: begin
                use_bt = 1'b1;
            end
            M_SEPAR: begin
                if (!is_ws(i_char)) begin
                    o_step.res.items[k] = mk_res(K_SEPAR, 1'b0, 8'h00);
                    k = k + 2'd1;
                    use_bt = 1'b1;
                end
            end
            M_WORD: begin
                if (!ends_word(i_char)) begin
                    o_step.res.items[k] = mk_res(K_STRING, 1'b1, i_char);
                    k = k + 2'd1;
                end else if (is_quote(i_char)) begin
                    o_step.mode      = M_QUOTE;
                    o_step.quote_dbl = (i_char == C_DQUOTE);
                end else begin
                    o_step.res.items[k] = mk_res(K_STRING, 1'b0, 8'h00);
                    k = k + 2'd1;
                    use_bt = 1'b1;
                end
            end
            M_QUOTE: begin
                if (i_char == close_q) begin
                    o_step.mode = M_WORD;
                end else if (i_char == C_NUL) begin
                    o_step.res.items[k] = mk_res(K_QERR, 1'b0, 8'h00);
                    k = k + 2'd1;
                    o_step.mode      = M_START;
                    o_step.quote_dbl = 1'b0;
                end else begin
                    o_step.res.items[k] = mk_res(K_STRING, 1'b1, i_char);
                    k = k + 2'd1;
                end
            end
            M_PIPE: begin
                if (i_char == C_PIPE) begin
                    o_step.res.items[k] = mk_res(K_OROR, 1'b0, 8'h00);
                    k = k + 2'd1;
                    o_step.mode = M_IDLE;
                end else begin
                    o_step.res.items[k] = mk_res(K_PIPE, 1'b0, 8'h00);
                    k = k + 2'd1;
                    use_bt = 1'b1;
                end
            end
            M_AMP: begin
                if (i_char == C_AMP) begin
                    o_step.res.items[k] = mk_res(K_ANDAND, 1'b0, 8'h00);
                    k = k + 2'd1;
                    o_step.mode = M_IDLE;
                end else begin
                    o_step.res.items[k] = mk_res(K_UNIMPL, 1'b0, 8'h00);
                    k = k + 2'd1;
                    use_bt = 1'b1;
                end
            end
            M_DOLLAR: begin
                if (is_quote(i_char)) begin
                    o_step.res.items[k] = mk_res(K_VAR, 1'b0, 8'h00);
                    k = k + 2'd1;
                    o_step.mode      = M_QUOTE;
                    o_step.quote_dbl = (i_char == C_DQUOTE);
                end else if (is_alnum(i_char)) begin
                    o_step.res.items[k] = mk_res(K_VAR, 1'b1, i_char);
                    k = k + 2'd1;
                    o_step.mode = M_VAR;
                end else begin
                    o_step.res.items[k] = mk_res(K_STRING, 1'b1, C_DOLLAR);
                    k = k + 2'd1;
                    o_step.res.items[k] = mk_res(K_STRING, 1'b0, 8'h00);
                    k = k + 2'd1;
                    use_bt = 1'b1;
                end
            end
            M_VAR: begin
                if (is_alnum(i_char)) begin
                    o_step.res.items[k] = mk_res(K_VAR, 1'b1, i_char);
                    k = k + 2'd1;
                end else begin
                    o_step.res.items[k] = mk_res(K_VAR, 1'b0, 8'h00);
                    k = k + 2'd1;
                    use_bt = 1'b1;
                end
            end
            default: begin
                if (!is_ws(i_char)) begin
                    use_bt = 1'b1;
                end else begin
                    o_step.mode = M_START;
                end
            end
        endcase
        if (use_bt) begin
            o_step.mode = bt_mode;
            if (bt_qd_wr) begin
                o_step.quote_dbl = bt_qd;
            end
            if (bt_has) begin
                o_step.res.items[k] = bt_item;
                k = k + 2'd1;
            end
        end
        o_step.res.cnt = k;
    end

endmodule
`default_nettype wire

FILE: sv/scl_outbuf.sv
// Result buffer: holds the up to three results of one character and sends
// them one per cycle on the master stream while m_axis_tready is high. Depends on scl_pkg.
`default_nettype none
module scl_outbuf import scl_pkg::*; (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_load,
    input  wire t_bundle    i_bundle,
    output logic            o_room,
    output logic            m_axis_tvalid,
    input  wire logic       m_axis_tready,
    output logic [7:0]      m_axis_tdata,  // text_byte
    output logic [4:0]      m_axis_tuser,  // tok_kind[3:0], is_text[4]
    output logic            m_axis_tlast
);

    t_res [MAX_RES-1:0] r_items;
    logic [1:0]         r_left;
    logic               pop;

    assign m_axis_tvalid = (r_left != 2'd0);
    assign pop           = m_axis_tvalid && m_axis_tready;
    assign o_room        = (r_left == 2'd0) || (r_left == 2'd1 && m_axis_tready);
    assign m_axis_tdata  = r_items[0].text_byte;
    assign m_axis_tuser  = {r_items[0].is_text, r_items[0].tok_kind};
    assign m_axis_tlast  = (r_left == 2'd1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left <= 2'd0;
        end else if (i_load) begin
            r_left <= i_bundle.cnt;
        end else if (pop) begin
            r_left <= r_left - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_items <= i_bundle.items;
        end else if (pop) begin
            r_items <= {r_items[MAX_RES-1], r_items[MAX_RES-1:1]};
        end
    end

    a_load_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_load && i_bundle.cnt != 2'd0) |=> m_axis_tvalid)
        else $error("loaded results not presented");

    a_drain_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pop && m_axis_tlast && !i_load) |=> !m_axis_tvalid)
        else $error("buffer still valid after final result");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_load |-> (r_left == 2'd0 || (r_left == 2'd1 && pop)))
        else $error("pending results overwritten");

endmodule
`default_nettype wire

FILE: sv/shell_command_lexer_core.sv
// Shell command line lexer: one character in, up to three token results out.
// Results are registered: the first shows on the master side in the cycle after
// its character is taken. One character per cycle while each yields at most one
// result and the master side is ready; a character with more results holds the
// slave side while the single result buffer drains them, one per ready cycle.
// Reset (synchronous, active low) returns the lexer to line start, buffer empty.
`default_nettype none
module shell_command_lexer_core import scl_pkg::*; (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       s_axis_tvalid,
    output logic            s_axis_tready,
    input  wire logic [7:0] s_axis_tdata,   // char_in
    output logic            m_axis_tvalid,
    input  wire logic       m_axis_tready,
    output logic [7:0]      m_axis_tdata,   // text_byte
    output logic [4:0]      m_axis_tuser,   // tok_kind[3:0], is_text[4]
    output logic            m_axis_tlast
);

    logic [3:0] r_mode;
    logic       r_quote_dbl;
    t_step      n_step;
    logic       accept;
    logic       room;

    scl_classify u_classify (
        .i_char      (s_axis_tdata),
        .i_mode      (r_mode),
        .i_quote_dbl (r_quote_dbl),
        .o_step      (n_step)
    );

    scl_outbuf u_outbuf (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_load        (accept),
        .i_bundle      (n_step.res),
        .o_room        (room),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    assign s_axis_tready = room;
    assign accept        = s_axis_tvalid && room;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= M_START;
            r_quote_dbl <= 1'b0;
        end else if (accept) begin
            r_mode      <= n_step.mode;
            r_quote_dbl <= n_step.quote_dbl;
        end
    end

    a_qerr_in_quote: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && n_step.res.cnt != 2'd0 && n_step.res.items[0].tok_kind == K_QERR)
        |-> r_mode == M_QUOTE)
        else $error("quote error outside quoted text");

    a_nul_to_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && s_axis_tdata == C_NUL) |=> (r_mode == M_START && !r_quote_dbl))
        else $error("line end did not return to line start");

endmodule
`default_nettype wire

FILE: dv/shell_command_lexer_core_tb.sv
// Testbench for shell_command_lexer_core: drives command-line bytes on the slave stream
// and checks every token result on the master stream against a cycle-free lexer predictor.
// Depends on scl_pkg for token kinds, lexer modes and character codes.
module shell_command_lexer_core_tb;
    import scl_pkg::*;

    localparam int DIRECT_ITEMS = 27;
    localparam int RANDOM_ITEMS = 330;
    localparam int STALL_LIMIT  = 1000;
    localparam int MAX_REPORTS  = 10;

    typedef struct {
        logic [3:0] kind;
        logic       txt;
        logic [7:0] text_b;
        logic       last;
    } t_tok_rec;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       s_axis_tvalid = 1'b0;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata = 8'h00;   // char_in
    logic       m_axis_tvalid;
    logic       m_axis_tready = 1'b0;
    logic [7:0] m_axis_tdata;           // text_byte
    logic [4:0] m_axis_tuser;           // tok_kind[3:0], is_text[4]
    logic       m_axis_tlast;

    logic [7:0] char_q[$];
    t_tok_rec   tok_expect[$];
    t_tok_rec   step_toks[0:2];
    int         step_n;

    logic [3:0] lx_mode = M_START;
    logic       lx_dq = 1'b0;

    int chars_in = 0;
    int toks_checked = 0;
    int lines_ended = 0;
    int quote_errs = 0;
    int mism = 0;
    int stall_cycles = 0;
    int total_chars;
    logic [31:0] cyc = 0;
    logic steady;

    shell_command_lexer_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    assign steady = (cyc[8:7] == 2'b11);

    function automatic logic blank_char(input logic [7:0] c);
        return c == C_SPACE || c == C_TAB || c == C_LF || c == C_VT || c == C_FF || c == C_CR;
    endfunction

    function automatic logic name_char(input logic [7:0] c);
        return (c >= "0" && c <= "9") || (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
    endfunction

    function automatic logic quote_char(input logic [7:0] c);
        return c == C_DQUOTE || c == C_SQUOTE;
    endfunction

    function automatic logic word_break(input logic [7:0] c);
        return c == C_NUL || blank_char(c) || quote_char(c) || c == C_PIPE || c == C_LT ||
               c == C_GT || c == C_SEMI || c == C_AMP || c == C_DOLLAR;
    endfunction

    task automatic emit_tok(input logic [3:0] kind, input logic txt, input logic [7:0] b);
        step_toks[step_n] = '{kind, txt, txt ? b : 8'h00, 1'b0};
        step_n++;
    endtask

    task automatic open_quote(input logic [7:0] c);
        lx_dq = (c == C_DQUOTE);
        lx_mode = M_QUOTE;
    endtask

    task automatic start_token(input logic [7:0] c);
        lx_mode = M_IDLE;
        if (blank_char(c)) begin
            lx_mode = M_SEPAR;
        end else if (c == C_NUL) begin
            emit_tok(K_END, 1'b0, 8'h00);
            lx_mode = M_START;
            lx_dq = 1'b0;
        end else if (c == C_SEMI) begin
            emit_tok(K_SEMI, 1'b0, 8'h00);
        end else if (c == C_PIPE) begin
            lx_mode = M_PIPE;
        end else if (c == C_AMP) begin
            lx_mode = M_AMP;
        end else if (c == C_LT) begin
            emit_tok(K_LT, 1'b0, 8'h00);
        end else if (c == C_GT) begin
            emit_tok(K_GT, 1'b0, 8'h00);
        end else if (c == C_DOLLAR) begin
            lx_mode = M_DOLLAR;
        end else if (quote_char(c)) begin
            open_quote(c);
        end else begin
            emit_tok(K_STRING, 1'b1, c);
            lx_mode = M_WORD;
        end
    endtask

    task automatic lex_step(input logic [7:0] c);
        t_tok_rec rec;
        step_n = 0;
        case (lx_mode)
            M_IDLE: start_token(c);
            M_SEPAR: begin
                if (!blank_char(c)) begin
                    emit_tok(K_SEPAR, 1'b0, 8'h00);
                    start_token(c);
                end
            end
            M_WORD: begin
                if (!word_break(c)) begin
                    emit_tok(K_STRING, 1'b1, c);
                end else if (quote_char(c)) begin
                    open_quote(c);
                end else begin
                    emit_tok(K_STRING, 1'b0, 8'h00);
                    start_token(c);
                end
            end
            M_QUOTE: begin
                if (c == (lx_dq ? C_DQUOTE : C_SQUOTE)) begin
                    lx_mode = M_WORD;
                end else if (c == C_NUL) begin
                    emit_tok(K_QERR, 1'b0, 8'h00);
                    lx_mode = M_START;
                    lx_dq = 1'b0;
                end else begin
                    emit_tok(K_STRING, 1'b1, c);
                end
            end
            M_PIPE: begin
                if (c == C_PIPE) begin
                    emit_tok(K_OROR, 1'b0, 8'h00);
                    lx_mode = M_IDLE;
                end else begin
                    emit_tok(K_PIPE, 1'b0, 8'h00);
                    start_token(c);
                end
            end
            M_AMP: begin
                if (c == C_AMP) begin
                    emit_tok(K_ANDAND, 1'b0, 8'h00);
                    lx_mode = M_IDLE;
                end else begin
                    emit_tok(K_UNIMPL, 1'b0, 8'h00);
                    start_token(c);
                end
            end
            M_DOLLAR: begin
                if (quote_char(c)) begin
                    emit_tok(K_VAR, 1'b0, 8'h00);
                    open_quote(c);
                end else if (name_char(c)) begin
                    emit_tok(K_VAR, 1'b1, c);
                    lx_mode = M_VAR;
                end else begin
                    emit_tok(K_STRING, 1'b1, C_DOLLAR);
                    emit_tok(K_STRING, 1'b0, 8'h00);
                    start_token(c);
                end
            end
            M_VAR: begin
                if (name_char(c)) begin
                    emit_tok(K_VAR, 1'b1, c);
                end else begin
                    emit_tok(K_VAR, 1'b0, 8'h00);
                    start_token(c);
                end
            end
            default: begin
                if (!blank_char(c))
                    start_token(c);
                else
                    lx_mode = M_START;
            end
        endcase
        for (int i = 0; i < step_n; i++) begin
            rec = step_toks[i];
            rec.last = (i == step_n - 1);
            tok_expect = {tok_expect, rec};
        end
    endtask

    function automatic logic [7:0] pick_blank();
        case ($urandom_range(5))
            0: return C_SPACE;
            1: return C_TAB;
            2: return C_LF;
            3: return C_VT;
            4: return C_FF;
            default: return C_CR;
        endcase
    endfunction

    function automatic logic [7:0] pick_name_char();
        logic [7:0] c;
        do c = 8'($urandom_range(8'h30, 8'h7A)); while (!name_char(c));
        return c;
    endfunction

    function automatic logic [7:0] pick_word_char();
        logic [7:0] c;
        if ($urandom_range(99) < 70)
            return pick_name_char();
        do c = 8'($urandom_range(1, 255)); while (word_break(c));
        return c;
    endfunction

    function automatic logic [7:0] pick_quote();
        return $urandom_range(1) ? C_DQUOTE : C_SQUOTE;
    endfunction

    task automatic add_char(input logic [7:0] c);
        char_q = {char_q, c};
    endtask

    task automatic put_quoted(input logic [7:0] q, input logic closed);
        logic [7:0] c;
        int n;
        n = $urandom_range(0, 4);
        add_char(q);
        for (int i = 0; i < n; i++) begin
            do c = 8'($urandom_range(1, 255)); while (c == q);
            add_char(c);
        end
        if (closed)
            add_char(q);
    endtask

    task automatic put_operator();
        case ($urandom_range(6))
            0: add_char(C_SEMI);
            1: add_char(C_PIPE);
            2: begin
                add_char(C_PIPE);
                add_char(C_PIPE);
            end
            3: add_char(C_AMP);
            4: begin
                add_char(C_AMP);
                add_char(C_AMP);
            end
            5: add_char(C_LT);
            default: add_char(C_GT);
        endcase
    endtask

    task automatic put_line();
        int ntok;
        int n;
        if ($urandom_range(99) < 10) begin
            n = $urandom_range(1, 12);
            for (int i = 0; i < n; i++)
                add_char(8'($urandom_range(0, 255)));
            add_char(C_NUL);
            return;
        end
        if ($urandom_range(1))
            add_char(pick_blank());
        ntok = $urandom_range(1, 6);
        for (int t = 0; t < ntok; t++) begin
            case ($urandom_range(7))
                0, 1: begin
                    n = $urandom_range(1, 5);
                    for (int i = 0; i < n; i++)
                        add_char(pick_word_char());
                    if ($urandom_range(99) < 25) begin
                        put_quoted(pick_quote(), 1'b1);
                        add_char(pick_word_char());
                    end
                end
                2: put_quoted(pick_quote(), 1'b1);
                3: begin
                    add_char(C_DOLLAR);
                    n = $urandom_range(1, 4);
                    for (int i = 0; i < n; i++)
                        add_char(pick_name_char());
                end
                4: begin
                    add_char(C_DOLLAR);
                    add_char(pick_blank());
                end
                5: begin
                    add_char(C_DOLLAR);
                    put_quoted(pick_quote(), 1'b1);
                end
                6: put_operator();
                default: add_char(8'($urandom_range(1, 255)));
            endcase
            if ($urandom_range(99) < 60) begin
                n = $urandom_range(1, 3);
                for (int i = 0; i < n; i++)
                    add_char(pick_blank());
            end
        end
        if ($urandom_range(99) < 8)
            put_quoted(pick_quote(), 1'b0);
        add_char(C_NUL);
    endtask

    task automatic put_text(input string s);
        for (int i = 0; i < s.len(); i++)
            add_char(s[i]);
    endtask

    initial begin
        add_char(C_TAB);
        put_text("$ab||&&d'e f'|&;<$ >");
        add_char(8'hFF);
        add_char(C_NUL);
        add_char(C_DOLLAR);
        add_char(C_DQUOTE);
        add_char(8'h80);
        add_char(C_NUL);
        while (char_q.size() < DIRECT_ITEMS + RANDOM_ITEMS)
            put_line();
        total_chars = char_q.size();

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        do @(negedge i_clk); while (chars_in != total_chars || tok_expect.size() != 0);
        repeat (10) @(negedge i_clk);

        $display("lexed %0d characters over %0d lines (%0d ended by a quote error)",
                 chars_in, lines_ended + quote_errs, quote_errs);
        $display("checked %0d token results, %0d wrong, %0d still owed",
                 toks_checked, mism, tok_expect.size());
        if (mism == 0 && tok_expect.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= 8'h00;
        end else if (!s_axis_tvalid || s_axis_tready) begin
            if (char_q.size() != 0 && (steady || $urandom_range(99) >= 22)) begin
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= char_q.pop_front();
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n)
            m_axis_tready <= 1'b0;
        else
            m_axis_tready <= steady || $urandom_range(99) >= 22;
    end

    always @(posedge i_clk) begin
        t_tok_rec want;
        logic     moved;
        cyc <= cyc + 1;
        moved = 1'b0;
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready) begin
                lex_step(s_axis_tdata);
                chars_in++;
                moved = 1'b1;
            end
            if (m_axis_tvalid && m_axis_tready) begin
                moved = 1'b1;
                toks_checked++;
                if (tok_expect.size() == 0) begin
                    mism++;
                    if (mism <= MAX_REPORTS)
                        $display("unexpected result: kind %0d text %0b byte %02h last %0b",
                                 m_axis_tuser[3:0], m_axis_tuser[4], m_axis_tdata,
                                 m_axis_tlast);
                end else begin
                    want = tok_expect.pop_front();
                    if (want.kind == K_END)
                        lines_ended++;
                    if (want.kind == K_QERR)
                        quote_errs++;
                    if (m_axis_tuser[3:0] !== want.kind || m_axis_tuser[4] !== want.txt ||
                        m_axis_tdata !== want.text_b || m_axis_tlast !== want.last) begin
                        mism++;
                        if (mism <= MAX_REPORTS)
                            $display({"result %0d: expected kind %0d text %0b byte %02h ",
                                      "last %0b, got kind %0d text %0b byte %02h last %0b"},
                                     toks_checked, want.kind, want.txt, want.text_b,
                                     want.last, m_axis_tuser[3:0], m_axis_tuser[4],
                                     m_axis_tdata, m_axis_tlast);
                    end
                end
            end
            if (moved)
                stall_cycles <= 0;
            else
                stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("stream stalled for %0d cycles", stall_cycles);
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

endmodule

FILE: files.f
sv/scl_pkg.sv
sv/scl_classify.sv
sv/scl_outbuf.sv
sv/shell_command_lexer_core.sv
dv/shell_command_lexer_core_tb.sv
